@@ rtl/apsp_pkg.sv @@
package apsp_pkg;

   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 19;
   localparam int COUNT_W  = 4;
   localparam int VERTEX_W = 4;
   localparam int OUT_VERTEX_W = 3;

   localparam logic [DIST_W-1:0] DIST_MAX = 19'h3FFFF;
   localparam logic [DIST_W-1:0] DIST_MIN = 19'h40000;

   typedef struct packed {
      logic                inf;
      logic [WEIGHT_W-1:0] weight;
   } edge_cell_type;

   typedef struct packed {
      logic              inf;
      logic [DIST_W-1:0] val;
   } dist_cell_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_PIV_RD,
      ST_PIV_LD,
      ST_RELAX_RD,
      ST_RELAX_WR,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_CLEAR
   } state_type;

   function automatic dist_cell_type edge_to_dist(input edge_cell_type e);
      dist_cell_type d;
      d.inf = e.inf;
      d.val = e.inf ? '0 : {{(DIST_W-WEIGHT_W){e.weight[WEIGHT_W-1]}}, e.weight};
      return d;
   endfunction

endpackage

@@ rtl/apsp_edge_store.sv @@
module apsp_edge_store #(
   parameter int IW = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   wr_en,
   input  logic [2*IW-1:0]        wr_addr,
   input  apsp_pkg::edge_cell_type wr_data,
   input  logic                   rd_en,
   input  logic [2*IW-1:0]        rd_addr,
   output apsp_pkg::edge_cell_type rd_data
);
   import apsp_pkg::*;

   localparam int DEPTH = 1 << (2*IW);

   edge_cell_type    mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   edge_cell_type    rd_data_ff;
   logic             rd_valid_ff;
   logic             rd_diag_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_diag_ff  <= (rd_addr[2*IW-1:IW] == rd_addr[IW-1:0]);
      end
   end

   // entries not written since the last clear read as the reset pattern
   always_comb begin
      if (rd_valid_ff) begin
         rd_data = rd_data_ff;
      end else begin
         rd_data.inf    = !rd_diag_ff;
         rd_data.weight = '0;
      end
   end

endmodule

@@ rtl/apsp_dist_store.sv @@
module apsp_dist_store #(
   parameter int IW = 3
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [2*IW-1:0]        wr_addr,
   input  apsp_pkg::dist_cell_type wr_data,
   input  logic                   rd_en,
   input  logic [2*IW-1:0]        rd_addr_a,
   input  logic [2*IW-1:0]        rd_addr_b,
   output apsp_pkg::dist_cell_type rd_data_a,
   output apsp_pkg::dist_cell_type rd_data_b
);
   import apsp_pkg::*;

   localparam int DEPTH = 1 << (2*IW);

   dist_cell_type mem [DEPTH];
   dist_cell_type rd_a_ff;
   dist_cell_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/apsp_relax.sv @@
module apsp_relax (
   input  apsp_pkg::dist_cell_type ik,
   input  apsp_pkg::dist_cell_type kj,
   input  apsp_pkg::dist_cell_type ij,
   output logic                   update,
   output apsp_pkg::dist_cell_type result
);
   import apsp_pkg::*;

   logic [DIST_W:0]   sum;
   logic [DIST_W-1:0] sat;

   always_comb begin
      sum = {ik.val[DIST_W-1], ik.val} + {kj.val[DIST_W-1], kj.val};
      // clamp to the distance range
      if (sum[DIST_W] != sum[DIST_W-1]) begin
         sat = sum[DIST_W] ? DIST_MIN : DIST_MAX;
      end else begin
         sat = sum[DIST_W-1:0];
      end
      update = !ik.inf && !kj.inf && (ij.inf || ($signed(sat) < $signed(ij.val)));
      result.inf = 1'b0;
      result.val = sat;
   end

endmodule

@@ rtl/all_pairs_shortest_paths_core.sv @@
// All-pairs shortest paths core. Edges are written one word per cycle, while
// the core is idle, into an edge store that starts with zero on the diagonal
// and no edge elsewhere; an edge naming a vertex at or above the vertex count
// is dropped. The word marked last starts Floyd-Warshall over the first n
// vertices (n is vertex_count, capped at MAX_VERTICES), after which the
// distance matrix is sent in row-major order, one word per pair, and the edge
// store returns to its reset contents. The whole matrix lives in a single
// dual-read distance memory with a registered read; after the last edge word
// come copy, relaxation, output (which waits while the result side stalls)
// and store clear, before the next edge word is taken.
module all_pairs_shortest_paths_core #(
   parameter int MAX_VERTICES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [3:0]          csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_src_vertex,
   input  logic [3:0]          req_dst_vertex,
   input  logic signed [15:0]  req_edge_weight,
   input  logic                req_edge_absent,
   input  logic                req_last_edge,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_from_vertex,
   output logic [2:0]          rsp_to_vertex,
   output logic signed [18:0]  rsp_distance,
   output logic                rsp_unreachable,
   output logic                rsp_last_pair
);
   import apsp_pkg::*;

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int AW = 2 * IW;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] vcount_ff;
   logic [NW-1:0]      n_used;
   logic [IW-1:0]      n_last;

   logic [IW-1:0] row_ff, row_in;
   logic [IW-1:0] col_ff, col_in;
   logic [IW-1:0] piv_ff, piv_in;
   dist_cell_type ik_ff, ik_in;

   logic col_wrap, row_wrap, piv_wrap, in_range;

   logic          edge_wr_en, edge_rd_en, edge_clear;
   logic [AW-1:0] edge_wr_addr;
   edge_cell_type edge_wr_data, edge_rd_data;

   logic          dist_wr_en, dist_rd_en;
   logic [AW-1:0] dist_wr_addr, dist_rd_addr_a, dist_rd_addr_b;
   dist_cell_type dist_wr_data, dist_rd_a, dist_rd_b;

   logic          relax_update;
   dist_cell_type relax_result;

   logic                    out_load;
   logic                    rsp_valid_ff;
   logic [OUT_VERTEX_W-1:0] from_ff, to_ff;
   logic [DIST_W-1:0]       dist_ff;
   logic                    unreach_ff, last_pair_ff;

   always_comb begin
      n_used = (vcount_ff > COUNT_W'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vcount_ff[NW-1:0];
      n_last = IW'(n_used - NW'(1));
   end

   assign col_wrap = (col_ff == n_last);
   assign row_wrap = (row_ff == n_last);
   assign piv_wrap = (piv_ff == n_last);
   assign in_range = (req_src_vertex < VERTEX_W'(n_used)) &&
                     (req_dst_vertex < VERTEX_W'(n_used));

   apsp_edge_store #(.IW(IW)) u_edge_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (edge_clear),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_en   (edge_rd_en),
      .rd_addr ({row_ff, col_ff}),
      .rd_data (edge_rd_data)
   );

   apsp_dist_store #(.IW(IW)) u_dist_store (
      .clock     (clock),
      .wr_en     (dist_wr_en),
      .wr_addr   (dist_wr_addr),
      .wr_data   (dist_wr_data),
      .rd_en     (dist_rd_en),
      .rd_addr_a (dist_rd_addr_a),
      .rd_addr_b (dist_rd_addr_b),
      .rd_data_a (dist_rd_a),
      .rd_data_b (dist_rd_b)
   );

   apsp_relax u_relax (
      .ik     (ik_ff),
      .kj     (dist_rd_b),
      .ij     (dist_rd_a),
      .update (relax_update),
      .result (relax_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_last_edge) begin
               state_in = (n_used == '0) ? ST_CLEAR : ST_COPY_RD;
            end
         end
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: begin
            state_in = (col_wrap && row_wrap) ? ST_PIV_RD : ST_COPY_RD;
         end
         ST_PIV_RD:   state_in = ST_PIV_LD;
         ST_PIV_LD:   state_in = ST_RELAX_RD;
         ST_RELAX_RD: state_in = ST_RELAX_WR;
         ST_RELAX_WR: begin
            if (!col_wrap) begin
               state_in = ST_RELAX_RD;
            end else if (row_wrap && piv_wrap) begin
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_PIV_RD;
            end
         end
         ST_OUT_RD: state_in = ST_OUT_LD;
         ST_OUT_LD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = (col_wrap && row_wrap) ? ST_CLEAR : ST_OUT_RD;
            end
         end
         ST_CLEAR: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      edge_wr_en     = 1'b0;
      edge_rd_en     = 1'b0;
      edge_clear     = 1'b0;
      edge_wr_addr   = {req_src_vertex[IW-1:0], req_dst_vertex[IW-1:0]};
      edge_wr_data.inf    = req_edge_absent;
      edge_wr_data.weight = req_edge_absent ? '0 : req_edge_weight;
      dist_wr_en     = 1'b0;
      dist_rd_en     = 1'b0;
      dist_wr_addr   = {row_ff, col_ff};
      dist_wr_data   = edge_to_dist(edge_rd_data);
      dist_rd_addr_a = {row_ff, col_ff};
      dist_rd_addr_b = {piv_ff, col_ff};
      out_load       = 1'b0;
      row_in         = row_ff;
      col_in         = col_ff;
      piv_in         = piv_ff;
      ik_in          = ik_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            edge_wr_en = req_valid && in_range;
            row_in     = '0;
            col_in     = '0;
            piv_in     = '0;
         end
         ST_COPY_RD: edge_rd_en = 1'b1;
         ST_COPY_WR: begin
            dist_wr_en = 1'b1;
            col_in     = col_wrap ? '0 : col_ff + 1'b1;
            if (col_wrap) begin
               row_in = row_wrap ? '0 : row_ff + 1'b1;
            end
         end
         ST_PIV_RD: begin
            dist_rd_en     = 1'b1;
            dist_rd_addr_a = {row_ff, piv_ff};
         end
         ST_PIV_LD: begin
            ik_in  = dist_rd_a;
            col_in = '0;
         end
         ST_RELAX_RD: dist_rd_en = 1'b1;
         ST_RELAX_WR: begin
            dist_wr_en   = relax_update;
            dist_wr_data = relax_result;
            // keep the held row-pivot term in step with its own update
            if (relax_update && (col_ff == piv_ff)) begin
               ik_in = relax_result;
            end
            col_in = col_wrap ? '0 : col_ff + 1'b1;
            if (col_wrap) begin
               row_in = row_wrap ? '0 : row_ff + 1'b1;
               if (row_wrap) begin
                  piv_in = piv_wrap ? '0 : piv_ff + 1'b1;
               end
            end
         end
         ST_OUT_RD: dist_rd_en = 1'b1;
         ST_OUT_LD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               col_in   = col_wrap ? '0 : col_ff + 1'b1;
               if (col_wrap) begin
                  row_in = row_wrap ? '0 : row_ff + 1'b1;
               end
            end
         end
         ST_CLEAR: edge_clear = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= COUNT_W'(8);
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         piv_ff       <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         piv_ff   <= piv_in;
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ik_ff <= ik_in;
      if (out_load) begin
         from_ff      <= OUT_VERTEX_W'(row_ff);
         to_ff        <= OUT_VERTEX_W'(col_ff);
         dist_ff      <= dist_rd_a.inf ? '0 : dist_rd_a.val;
         unreach_ff   <= dist_rd_a.inf;
         last_pair_ff <= col_wrap && row_wrap;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_from_vertex = from_ff;
   assign rsp_to_vertex   = to_ff;
   assign rsp_distance    = dist_ff;
   assign rsp_unreachable = unreach_ff;
   assign rsp_last_pair   = last_pair_ff;

endmodule
